[rtl/lfmq_pkg.sv]
// shared types, codes and constants of the line framer message queue
`timescale 1ns / 1ps
package lfmq_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_MAX_MESSAGE    = 64;
  localparam int DEF_QUEUE_CAPACITY = 16;

  // index field of a command word, wide enough for the largest line
  localparam int CMD_IDX_W = 12;

  // depth of the command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // input actions
  localparam logic [1:0] ACT_STREAM  = 2'd0;
  localparam logic [1:0] ACT_POP     = 2'd1;
  localparam logic [1:0] ACT_NEWCONN = 2'd2;
  localparam logic [1:0] ACT_CLEAR   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_EMPTY     = 2'd1;
  localparam logic [1:0] KIND_TOO_LARGE = 2'd2;
  localparam logic [1:0] KIND_ROOM_ZERO = 2'd3;

  // line delimiters
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // commands from front to back
  typedef enum logic [2:0] {
    CMD_COPY  = 3'd0,
    CMD_EOL   = 3'd1,
    CMD_DROP  = 3'd2,
    CMD_POP   = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [7:0]           data;
    logic [CMD_IDX_W-1:0] idx;
    logic [15:0]          room;
  } cmd_word_t;

  // input word
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [15:0] room;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [5:0]  msg_length;
    logic        last;
    logic [31:0] drop_total;
  } out_word_t;

endpackage

[rtl/line_framer_message_queue_core.sv]
// Line framer with message queue, top level.
//
// Input channel: push/full with in_word {action, data_byte, room}. A word is
// taken at a clock edge with push high and full low. Stream bytes build a
// line ended by newline; carriage returns are skipped. Pops, new connection
// and clear are given as actions on the same channel.
// Result channel: empty/pop with out_word {kind, out_byte, msg_length,
// last, drop_total}; the oldest result waits while empty is low.
// Throughput: stream bytes, new connection, clear and pops are taken one per
// cycle while full is low. A newline that closes a non-empty line keeps full
// high while the line is copied from the line buffer into the ring, one byte
// per cycle over its single read port while the command queue has room.
// A pop passes the command queue; with the back end idle, an empty or zero-room
// status goes to the output register, too large after the length store read,
// the first message byte after the length and message store reads. Later bytes
// follow one per cycle while the output is free, set by the store's one read port.
// Reset (rst_n low, synchronous) empties the ring, the partial line and the
// command queue and zeroes the drop counter; no clearing pass is needed.
// While the receiver holds pop low, results stay in the output register,
// the back end stalls, and after the command queue fills, full rises.
`timescale 1ns / 1ps
module line_framer_message_queue_core #(
  parameter int MAX_MESSAGE    = lfmq_pkg::DEF_MAX_MESSAGE,
  parameter int QUEUE_CAPACITY = lfmq_pkg::DEF_QUEUE_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  lfmq_pkg::in_word_t  in_word,
  output logic                empty,
  input  logic                pop,
  output lfmq_pkg::out_word_t out_word
);
  import lfmq_pkg::*;

  logic      cq_push;
  logic      cq_full;
  logic      cq_pop;
  logic      cq_empty;
  cmd_word_t cq_wr_word;
  cmd_word_t cq_rd_word;

  // front end: line assembly
  lfmq_front #(
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .cq_push (cq_push),
    .cq_word (cq_wr_word),
    .cq_full (cq_full)
  );

  // command queue
  lfmq_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cq_push),
    .wr_word (cq_wr_word),
    .full    (cq_full),
    .rd_en   (cq_pop),
    .rd_word (cq_rd_word),
    .empty   (cq_empty)
  );

  // back end: ring and results
  lfmq_back #(
    .MAX_MESSAGE    (MAX_MESSAGE),
    .QUEUE_CAPACITY (QUEUE_CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_word  (cq_rd_word),
    .cq_pop   (cq_pop),
    .pop      (pop),
    .empty    (empty),
    .out_word (out_word)
  );

`ifndef NO_ASSERTIONS
  // front never writes a full command queue
  a_cq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cq_push |-> !cq_full)
    else $error("command queue written while full");

  // back never reads an empty command queue
  a_cq_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> !cq_empty)
    else $error("command queue read while empty");

  // status results are single, marked last and carry no byte
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_word.kind != KIND_BYTE) |-> (out_word.last && out_word.out_byte == 8'd0))
    else $error("status result without last or with a byte");
`endif

endmodule

[rtl/lfmq_front.sv]
// front end: takes input words, gathers lines and issues commands to the back end
`timescale 1ns / 1ps
module lfmq_front #(
  parameter int MAX_MESSAGE = lfmq_pkg::DEF_MAX_MESSAGE
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  lfmq_pkg::in_word_t  in_word,
  output logic                cq_push,
  output lfmq_pkg::cmd_word_t cq_word,
  input  logic                cq_full
);
  import lfmq_pkg::*;

  localparam int LEN_W = $clog2(MAX_MESSAGE);
  localparam int DEPTH = MAX_MESSAGE - 1;
  localparam int IDX_W = (MAX_MESSAGE > 2) ? $clog2(MAX_MESSAGE - 1) : 1;
  localparam logic [LEN_W-1:0] LINE_LIMIT = LEN_W'(MAX_MESSAGE - 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_COPY = 3'b010,
    F_EOL  = 3'b100
  } front_state_t;

  front_state_t     state_r, state_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LEN_W-1:0] copy_len_r, copy_len_nxt;
  logic [LEN_W-1:0] iss_r, iss_nxt;
  logic             stg_v_r, stg_v_nxt;
  logic [LEN_W-1:0] stg_idx_r, stg_idx_nxt;
  logic [7:0]       stg_data_r;
  logic [7:0]       line_mem [DEPTH];
  logic             accept;
  logic             wr_en;
  logic             rd_en;
  logic             push_copy;

  assign full   = (state_r != F_IDLE) || cq_full;
  assign accept = push && !full;

  // classify words and sequence the line copy
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    copy_len_nxt = copy_len_r;
    iss_nxt      = iss_r;
    stg_v_nxt    = stg_v_r;
    stg_idx_nxt  = stg_idx_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    push_copy    = 1'b0;
    cq_push      = 1'b0;
    cq_word      = '0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          case (in_word.action)
            ACT_STREAM: begin
              if (in_word.data_byte == CHAR_LF) begin
                if (ovf_r) begin
                  cq_push    = 1'b1;
                  cq_word.op = CMD_DROP;
                end else if (count_r != '0) begin
                  state_nxt    = F_COPY;
                  copy_len_nxt = count_r;
                  iss_nxt      = '0;
                end
                count_nxt = '0;
                ovf_nxt   = 1'b0;
              end else if (in_word.data_byte != CHAR_CR && !ovf_r) begin
                if (count_r == LINE_LIMIT) begin
                  ovf_nxt = 1'b1;
                end else begin
                  wr_en     = 1'b1;
                  count_nxt = count_r + 1'b1;
                end
              end
            end
            ACT_POP: begin
              cq_push      = 1'b1;
              cq_word.op   = CMD_POP;
              cq_word.room = in_word.room;
            end
            ACT_NEWCONN: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            ACT_CLEAR: begin
              cq_push    = 1'b1;
              cq_word.op = CMD_CLEAR;
            end
            default: ;
          endcase
        end
      end
      F_COPY: begin
        // one line byte per cycle through a registered read stage while the command queue has room
        push_copy    = stg_v_r && !cq_full;
        cq_push      = push_copy;
        cq_word.op   = CMD_COPY;
        cq_word.data = stg_data_r;
        cq_word.idx  = CMD_IDX_W'(stg_idx_r);
        rd_en        = (iss_r != copy_len_r) && (!stg_v_r || push_copy);
        if (rd_en) begin
          iss_nxt     = iss_r + 1'b1;
          stg_v_nxt   = 1'b1;
          stg_idx_nxt = iss_r;
        end else if (push_copy) begin
          stg_v_nxt = 1'b0;
        end
        if ((iss_r == copy_len_r) && (!stg_v_r || push_copy)) begin
          state_nxt = F_EOL;
        end
      end
      F_EOL: begin
        if (!cq_full) begin
          cq_push     = 1'b1;
          cq_word.op  = CMD_EOL;
          cq_word.idx = CMD_IDX_W'(copy_len_r);
          state_nxt   = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      stg_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      stg_v_r <= stg_v_nxt;
    end
  end

  // copy bookkeeping
  always_ff @(posedge clk) begin
    copy_len_r <= copy_len_nxt;
    iss_r      <= iss_nxt;
    stg_idx_r  <= stg_idx_nxt;
  end

  // line store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[count_r[IDX_W-1:0]] <= in_word.data_byte;
    end
    if (rd_en) begin
      stg_data_r <= line_mem[iss_r[IDX_W-1:0]];
    end
  end

endmodule

[rtl/lfmq_cmd_fifo.sv]
// short command queue between the front end and the back end
`timescale 1ns / 1ps
module lfmq_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  lfmq_pkg::cmd_word_t wr_word,
  output logic                full,
  input  logic                rd_en,
  output lfmq_pkg::cmd_word_t rd_word,
  output logic                empty
);
  import lfmq_pkg::*;

  cmd_word_t            mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_word = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

endmodule

[rtl/lfmq_back.sv]
// back end: message ring, drop counter and result generation
`timescale 1ns / 1ps
module lfmq_back #(
  parameter int MAX_MESSAGE    = lfmq_pkg::DEF_MAX_MESSAGE,
  parameter int QUEUE_CAPACITY = lfmq_pkg::DEF_QUEUE_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cq_empty,
  input  lfmq_pkg::cmd_word_t cq_word,
  output logic                cq_pop,
  input  logic                pop,
  output logic                empty,
  output lfmq_pkg::out_word_t out_word
);
  import lfmq_pkg::*;

  localparam int LEN_W     = $clog2(MAX_MESSAGE);
  localparam int SLOT_W    = (QUEUE_CAPACITY > 1) ? $clog2(QUEUE_CAPACITY) : 1;
  localparam int USED_W    = $clog2(QUEUE_CAPACITY + 1);
  localparam int MSG_DEPTH = QUEUE_CAPACITY * (2 ** LEN_W);
  localparam int MSG_AW    = $clog2(MSG_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_CAPACITY - 1);
  localparam logic [USED_W-1:0] USED_FULL = USED_W'(QUEUE_CAPACITY);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_LEN   = 3'b010,
    B_BYTES = 3'b100
  } back_state_t;

  back_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [31:0]       drop_r, drop_nxt;
  logic [15:0]       room_r, room_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  iss_r, iss_nxt;
  logic              stg_v_r, stg_v_nxt;
  logic [LEN_W-1:0]  stg_idx_r, stg_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r;
  out_word_t         out_new;
  logic              out_load;
  logic              out_free;
  logic              ring_full;
  logic              too_big;
  logic              move;
  logic              msg_we, msg_re, len_we, len_re;
  logic [MSG_AW-1:0] msg_waddr, msg_raddr;
  logic [7:0]        msg_mem [MSG_DEPTH];
  logic [LEN_W-1:0]  len_mem [QUEUE_CAPACITY];
  logic [7:0]        msg_rd_r;
  logic [LEN_W-1:0]  len_rd_r;

  assign empty     = !out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || pop;
  assign ring_full = (used_r == USED_FULL);
  assign too_big   = ((17)'(len_rd_r) + 17'd1) > {1'b0, room_r};
  assign msg_waddr = MSG_AW'({wr_slot_r, cq_word.idx[LEN_W-1:0]});
  assign msg_raddr = MSG_AW'({rd_slot_r, iss_r});

  // command execution and result sequencing
  always_comb begin
    state_nxt   = state_r;
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    used_nxt    = used_r;
    drop_nxt    = drop_r;
    room_nxt    = room_r;
    len_nxt     = len_r;
    iss_nxt     = iss_r;
    stg_v_nxt   = stg_v_r;
    stg_idx_nxt = stg_idx_r;
    cq_pop      = 1'b0;
    msg_we      = 1'b0;
    msg_re      = 1'b0;
    len_we      = 1'b0;
    len_re      = 1'b0;
    move        = 1'b0;
    out_load    = 1'b0;
    out_new     = '0;
    out_new.drop_total = drop_r;
    case (state_r)
      B_IDLE: begin
        if (!cq_empty) begin
          case (cq_word.op)
            CMD_COPY: begin
              // a full ring keeps its oldest entry intact
              cq_pop = 1'b1;
              msg_we = !ring_full;
            end
            CMD_EOL: begin
              cq_pop = 1'b1;
              if (ring_full) begin
                drop_nxt = drop_r + 32'd1;
              end else begin
                len_we      = 1'b1;
                wr_slot_nxt = (wr_slot_r == SLOT_LAST) ? '0 : wr_slot_r + 1'b1;
                used_nxt    = used_r + 1'b1;
              end
            end
            CMD_DROP: begin
              cq_pop   = 1'b1;
              drop_nxt = drop_r + 32'd1;
            end
            CMD_CLEAR: begin
              cq_pop      = 1'b1;
              wr_slot_nxt = '0;
              rd_slot_nxt = '0;
              used_nxt    = '0;
              drop_nxt    = '0;
            end
            CMD_POP: begin
              if (cq_word.room == '0) begin
                if (out_free) begin
                  cq_pop       = 1'b1;
                  out_load     = 1'b1;
                  out_new.kind = KIND_ROOM_ZERO;
                  out_new.last = 1'b1;
                end
              end else if (used_r == '0) begin
                if (out_free) begin
                  cq_pop       = 1'b1;
                  out_load     = 1'b1;
                  out_new.kind = KIND_EMPTY;
                  out_new.last = 1'b1;
                end
              end else begin
                cq_pop    = 1'b1;
                len_re    = 1'b1;
                room_nxt  = cq_word.room;
                state_nxt = B_LEN;
              end
            end
            default: begin
              cq_pop = 1'b1;
            end
          endcase
        end
      end
      B_LEN: begin
        if (too_big) begin
          if (out_free) begin
            out_load           = 1'b1;
            out_new.kind       = KIND_TOO_LARGE;
            out_new.msg_length = 6'(len_rd_r);
            out_new.last       = 1'b1;
            rd_slot_nxt = (rd_slot_r == SLOT_LAST) ? '0 : rd_slot_r + 1'b1;
            used_nxt    = used_r - 1'b1;
            state_nxt   = B_IDLE;
          end
        end else begin
          len_nxt   = len_rd_r;
          iss_nxt   = '0;
          stg_v_nxt = 1'b0;
          state_nxt = B_BYTES;
        end
      end
      B_BYTES: begin
        // one message byte per cycle through a registered read stage while the output register is free
        move   = stg_v_r && out_free;
        msg_re = (iss_r != len_r) && (!stg_v_r || move);
        if (msg_re) begin
          iss_nxt     = iss_r + 1'b1;
          stg_v_nxt   = 1'b1;
          stg_idx_nxt = iss_r;
        end else if (move) begin
          stg_v_nxt = 1'b0;
        end
        if (move) begin
          out_load           = 1'b1;
          out_new.kind       = KIND_BYTE;
          out_new.out_byte   = msg_rd_r;
          out_new.msg_length = 6'(len_r);
          out_new.last       = (stg_idx_r == len_r - 1'b1);
          if (stg_idx_r == len_r - 1'b1) begin
            rd_slot_nxt = (rd_slot_r == SLOT_LAST) ? '0 : rd_slot_r + 1'b1;
            used_nxt    = used_r - 1'b1;
            state_nxt   = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      wr_slot_r   <= '0;
      rd_slot_r   <= '0;
      used_r      <= '0;
      drop_r      <= '0;
      stg_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_slot_r   <= wr_slot_nxt;
      rd_slot_r   <= rd_slot_nxt;
      used_r      <= used_nxt;
      drop_r      <= drop_nxt;
      stg_v_r     <= stg_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // pop bookkeeping and result payload
  always_ff @(posedge clk) begin
    room_r    <= room_nxt;
    len_r     <= len_nxt;
    iss_r     <= iss_nxt;
    stg_idx_r <= stg_idx_nxt;
    if (out_load) begin
      out_word_r <= out_new;
    end
  end

  // message store
  always_ff @(posedge clk) begin
    if (msg_we) begin
      msg_mem[msg_waddr] <= cq_word.data;
    end
    if (msg_re) begin
      msg_rd_r <= msg_mem[msg_raddr];
    end
  end

  // length store
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[wr_slot_r] <= cq_word.idx[LEN_W-1:0];
    end
    if (len_re) begin
      len_rd_r <= len_mem[rd_slot_r];
    end
  end

endmodule
